// File: rtl/core/iol_pkg.sv
// Shared types, codes and sizes for the indexed ordered list.
`timescale 1ns / 1ps
`default_nettype none

package iol_pkg;

    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_AT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    typedef logic [DATA_W-1:0] t_data;

    typedef struct packed {
        logic [1:0]       op;
        logic [CMP_W-1:0] at;
        t_data            value;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// File: rtl/core/iol_cell.sv
// One storage cell of the list row: hold, shift from a neighbor or load.
`timescale 1ns / 1ps
`default_nettype none

module iol_cell (
    input  wire                      i_clk,
    input  iol_pkg::t_cell_ctrl      i_ctrl,
    input  wire [iol_pkg::CMP_W-1:0] i_index,
    input  iol_pkg::t_data           i_left,
    input  iol_pkg::t_data           i_right,
    output iol_pkg::t_data           o_data
);
    import iol_pkg::*;

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INS: begin
                if (i_index > i_ctrl.at) begin
                    n_data = i_left;
                end else if (i_index == i_ctrl.at) begin
                    n_data = i_ctrl.value;
                end
            end
            OP_DEL: begin
                if (i_index >= i_ctrl.at) begin
                    n_data = i_right;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// File: rtl/core/iol_ctrl.sv
// Command decode: status, next count and the shift request for the cell row.
`timescale 1ns / 1ps
`default_nettype none

module iol_ctrl (
    input  wire                       i_accept,
    input  wire [iol_pkg::CMD_W-1:0]  i_cmd,
    input  wire [iol_pkg::POS_W-1:0]  i_position,
    input  iol_pkg::t_data            i_value,
    input  wire [iol_pkg::CNT_W-1:0]  i_count,
    output iol_pkg::t_cell_ctrl       o_ctrl,
    output logic [iol_pkg::STAT_W-1:0] o_status,
    output logic [iol_pkg::CNT_W-1:0] o_count,
    output logic                      o_read_ok
);
    import iol_pkg::*;

    logic [CMP_W-1:0] pos_w;
    logic [CMP_W-1:0] cnt_w;
    logic             full;
    logic             empty;
    logic [1:0]       op;
    logic [CMP_W-1:0] at;

    assign pos_w = CMP_W'(i_position);
    assign cnt_w = CMP_W'(i_count);
    assign full  = (i_count == CNT_W'(DEPTH));
    assign empty = (i_count == '0);

    always_comb begin
        op        = OP_HOLD;
        at        = '0;
        o_status  = ST_OK;
        o_read_ok = 1'b0;
        case (i_cmd)
            CMD_INS_AT: begin
                at = pos_w;
                if (pos_w > cnt_w) begin
                    o_status = ST_BAD_INDEX;
                end else if (full) begin
                    o_status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_READ: begin
                if (pos_w < cnt_w) begin
                    o_read_ok = 1'b1;
                end else begin
                    o_status = ST_BAD_INDEX;
                end
            end
            CMD_DEL_AT: begin
                at = pos_w;
                if (empty) begin
                    o_status = ST_EMPTY;
                end else if (pos_w >= cnt_w) begin
                    o_status = ST_BAD_INDEX;
                end else begin
                    op = OP_DEL;
                end
            end
            CMD_INS_HEAD: begin
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_INS_TAIL: begin
                at = cnt_w;
                if (full) begin
                    o_status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_DEL_HEAD: begin
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    op = OP_DEL;
                end
            end
            CMD_DEL_TAIL: begin
                at = cnt_w - CMP_W'(1);
                if (empty) begin
                    o_status = ST_EMPTY;
                end else begin
                    op = OP_DEL;
                end
            end
            default: begin
                o_status = ST_BAD_INDEX;
            end
        endcase
    end

    always_comb begin
        o_count = i_count;
        if (op == OP_INS) begin
            o_count = i_count + CNT_W'(1);
        end else if (op == OP_DEL) begin
            o_count = i_count - CNT_W'(1);
        end
    end

    assign o_ctrl.op    = i_accept ? op : OP_HOLD;
    assign o_ctrl.at    = at;
    assign o_ctrl.value = i_value;

endmodule

`default_nettype wire

// File: rtl/core/indexed_ordered_list.sv
// Top level of the indexed ordered list: decode, cell row and result register.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_cmd, i_position, i_item_value
//  out     | out       | o_out_valid / i_out_stall | o_status, o_read_value, o_entry_count
//
// For every accepted request the cell row shifts all entries together, in parallel.
// A result appears in the cycle after its request is accepted.
// A new request is taken while the held result is taken in the same cycle.
// Reset (synchronous, active low) empties the list; entry contents are left as they are.
// A stalled output stalls the input until the held result is taken.
`timescale 1ns / 1ps
`default_nettype none

module indexed_ordered_list (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire [iol_pkg::CMD_W-1:0]          i_cmd,
    input  wire [iol_pkg::POS_W-1:0]          i_position,
    input  wire signed [iol_pkg::DATA_W-1:0]  i_item_value,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [iol_pkg::STAT_W-1:0]        o_status,
    output logic signed [iol_pkg::DATA_W-1:0] o_read_value,
    output logic [iol_pkg::POS_W-1:0]         o_entry_count
);
    import iol_pkg::*;

    logic              accept;
    t_cell_ctrl        cell_ctrl;
    logic [STAT_W-1:0] dec_status;
    logic [CNT_W-1:0]  dec_count;
    logic              read_ok;
    t_data             cell_data [DEPTH];
    logic [IDX_W-1:0]  rd_idx;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  cnt_ext;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    t_data             r_read_value;
    logic [POS_W-1:0]  r_entry_count;
    logic [CNT_W-1:0]  r_count;

    t_data             n_read_value;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    iol_ctrl u_ctrl (
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_position (i_position),
        .i_value    (t_data'(i_item_value)),
        .i_count    (r_count),
        .o_ctrl     (cell_ctrl),
        .o_status   (dec_status),
        .o_count    (dec_count),
        .o_read_ok  (read_ok)
    );

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_data left_data;
        t_data right_data;

        if (k == 0) begin : g_first
            assign left_data = cell_ctrl.value;
        end else begin : g_mid_l
            assign left_data = cell_data[k-1];
        end

        if (k == DEPTH - 1) begin : g_last
            assign right_data = cell_data[k];
        end else begin : g_mid_r
            assign right_data = cell_data[k+1];
        end

        iol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl),
            .i_index (CMP_W'(k)),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[k])
        );
    end

    assign pos_w   = CMP_W'(i_position);
    assign rd_idx  = pos_w[IDX_W-1:0];
    assign cnt_ext = CMP_W'(dec_count);

    always_comb begin
        n_read_value = '0;
        if (i_cmd == CMD_READ) begin
            n_read_value = read_ok ? cell_data[rd_idx] : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= dec_count;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= dec_status;
            r_read_value  <= n_read_value;
            r_entry_count <= cnt_ext[POS_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = signed'(r_read_value);
    assign o_entry_count = r_entry_count;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the indexed ordered list with directed and random requests.
`timescale 1ns / 1ps

module testbench;
    import iol_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS = 1530;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  pos;
        t_data             val;
    } t_request;

    typedef struct {
        logic [STAT_W-1:0] status;
        t_data             rd;
        logic [POS_W-1:0]  cnt;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [CMD_W-1:0]   i_cmd = '0;
    logic [POS_W-1:0]   i_position = '0;
    logic [DATA_W-1:0]  i_item_value = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [STAT_W-1:0]  o_status;
    logic [DATA_W-1:0]  o_read_value;
    logic [POS_W-1:0]   o_entry_count;

    t_request request_q[$];
    t_answer  answer_q[$];
    t_data    cells[DEPTH];
    int       fill = 0;
    int       mismatches = 0;
    int       cycles = 0;
    bit       req_taken = 1'b0;
    bit       idling = 1'b1;
    int       gap_pct = 0;
    int       stall_pct = 0;
    int       gap_left = 0;
    int       stall_left = 0;

    indexed_ordered_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_position    (i_position),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [STAT_W-1:0] shift_in(int at, t_data v);
        if (at > fill) return ST_BAD_INDEX;
        if (fill >= DEPTH) return ST_FULL;
        for (int k = fill; k > at; k--) cells[k] = cells[k-1];
        cells[at] = v;
        fill++;
        return ST_OK;
    endfunction

    function automatic logic [STAT_W-1:0] shift_out(int at);
        if (fill == 0) return ST_EMPTY;
        if (at >= fill) return ST_BAD_INDEX;
        for (int k = at; k + 1 < fill; k++) cells[k] = cells[k+1];
        fill--;
        return ST_OK;
    endfunction

    function automatic t_answer apply_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                              t_data val);
        t_answer a;
        a.status = ST_OK;
        a.rd = '0;
        case (cmd)
            CMD_INS_AT:   a.status = shift_in(int'(pos), val);
            CMD_READ: begin
                if (int'(pos) < fill) begin
                    a.rd = cells[pos[IDX_W-1:0]];
                end else begin
                    a.status = ST_BAD_INDEX;
                    a.rd = '1;
                end
            end
            CMD_DEL_AT:   a.status = shift_out(int'(pos));
            CMD_INS_HEAD: a.status = shift_in(0, val);
            CMD_INS_TAIL: a.status = shift_in(fill, val);
            CMD_DEL_HEAD: a.status = shift_out(0);
            CMD_DEL_TAIL: a.status = (fill == 0) ? ST_EMPTY : shift_out(fill - 1);
            default:      a.status = ST_BAD_INDEX;
        endcase
        a.cnt = fill[POS_W-1:0];
        return a;
    endfunction

    task automatic add_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos, t_data val);
        t_request r;
        r.cmd = cmd;
        r.pos = pos;
        r.val = val;
        request_q.push_back(r);
    endtask

    function automatic t_data pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_request make_request(int ins_pct);
        t_request r;
        int lo_fill;
        lo_fill = (fill > 0) ? fill - 1 : 0;
        r.val = pick_value();
        r.pos = '0;
        if ($urandom_range(0, 99) < 6) begin
            r.cmd = CMD_W'($urandom_range(0, 7));
            r.pos = POS_W'($urandom_range(0, 31));
        end else if ($urandom_range(0, 99) < ins_pct) begin
            case ($urandom_range(0, 3))
                0:       r.cmd = CMD_INS_HEAD;
                1:       r.cmd = CMD_INS_TAIL;
                default: r.cmd = CMD_INS_AT;
            endcase
            r.pos = POS_W'($urandom_range(0, fill));
        end else begin
            case ($urandom_range(0, 4))
                0, 1:    r.cmd = CMD_READ;
                2:       r.cmd = CMD_DEL_AT;
                3:       r.cmd = CMD_DEL_HEAD;
                default: r.cmd = CMD_DEL_TAIL;
            endcase
            r.pos = POS_W'($urandom_range(0, lo_fill));
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answer_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result status=%0d value=%0d count=%0d",
                         $time, o_status, $signed(o_read_value), o_entry_count);
            end else begin
                want = answer_q.pop_front();
                if (o_status !== want.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d got %0d", $time, want.status, o_status);
                end
                if (o_read_value !== want.rd) begin
                    mismatches++;
                    $display("%0t: read value expected %0d got %0d", $time,
                             $signed(want.rd), $signed(o_read_value));
                end
                if (o_entry_count !== want.cnt) begin
                    mismatches++;
                    $display("%0t: count expected %0d got %0d", $time, want.cnt, o_entry_count);
                end
            end
        end
        req_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (req_taken) begin
            answer_q.push_back(apply_request(i_cmd, i_position, i_item_value));
        end
    end

    always @(negedge i_clk) begin
        t_request r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (idling && $urandom_range(0, 99) < gap_pct) begin
                gap_left = $urandom_range(1, 14) - 1;
                i_in_valid <= 1'b0;
            end else if (request_q.size() > 0) begin
                r = request_q.pop_front();
                i_in_valid   <= 1'b1;
                i_cmd        <= r.cmd;
                i_position   <= r.pos;
                i_item_value <= r.val;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || !idling) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        int ins_pct;
        // empty list corner requests
        add_request(CMD_READ, 5'd0, '0);
        add_request(CMD_DEL_AT, 5'd0, '0);
        add_request(CMD_DEL_HEAD, 5'd0, '0);
        add_request(CMD_DEL_TAIL, 5'd0, '0);
        add_request(CMD_UNUSED, 5'd31, 32'hFFFF_FFFF);
        add_request(CMD_INS_AT, 5'd1, 32'h1234_5678);
        // one-element list, tail delete empties it
        add_request(CMD_INS_AT, 5'd0, 32'h7FFF_FFFF);
        add_request(CMD_DEL_TAIL, 5'd0, '0);
        add_request(CMD_INS_HEAD, 5'd0, 32'h8000_0000);
        add_request(CMD_INS_TAIL, 5'd0, 32'hFFFF_FFFF);
        add_request(CMD_INS_AT, 5'd1, 32'h0000_0000);
        add_request(CMD_READ, 5'd31, '0);
        add_request(CMD_READ, 5'd3, '0);
        add_request(CMD_DEL_AT, 5'd3, '0);
        add_request(CMD_READ, 5'd0, '0);
        add_request(CMD_READ, 5'd1, '0);
        add_request(CMD_READ, 5'd2, '0);
        add_request(CMD_DEL_AT, 5'd1, '0);
        add_request(CMD_DEL_HEAD, 5'd0, '0);
        add_request(CMD_READ, 5'd0, '0);
        add_request(CMD_UNUSED, 5'd0, '0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        ins_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 3))
                    0:       ins_pct = 20;
                    1:       ins_pct = 50;
                    2:       ins_pct = 80;
                    default: ins_pct = 95;
                endcase
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 5;
                    default: gap_pct = 20;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 5;
                    default: stall_pct = 20;
                endcase
            end
            if (n == RANDOM_ITEMS - QUIET_TAIL) idling = 1'b0;
            while (request_q.size() >= 2) @(posedge i_clk);
            request_q.push_back(make_request(ins_pct));
        end

        while (request_q.size() > 0 || i_in_valid || answer_q.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
